FILE: sv/chsm_pkg.sv
// Shared types and constants for the chained hash store.
// Used by chsm_hash and chained_hash_store_mtf_unit; no dependencies.
package chsm_pkg;

   // request kinds
   localparam logic [2:0] KIND_GET     = 3'd0;
   localparam logic [2:0] KIND_PUT     = 3'd1;
   localparam logic [2:0] KIND_PUT_NEW = 3'd2;
   localparam logic [2:0] KIND_RESTART = 3'd3;
   localparam logic [2:0] KIND_NEXT    = 3'd4;

   // response status codes
   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_MISS = 2'd1;
   localparam logic [1:0] STAT_END  = 2'd2;
   localparam logic [1:0] STAT_FULL = 2'd3;

   // djb2 hash
   localparam int         HASH_BITS  = 64;
   localparam logic [63:0] HASH_SEED = 64'd5381;
   localparam int         HASH_SHIFT = 5;
   localparam int         HCNT_W     = 7;

   typedef struct packed {
      logic busy;
      logic done;
   } hash_stat_type;

   typedef enum logic [13:0] {
      S_IDLE  = 14'b00000000000001,
      S_CLEAR = 14'b00000000000010,
      S_HASH  = 14'b00000000000100,
      S_BIN   = 14'b00000000001000,
      S_WALK  = 14'b00000000010000,
      S_WCMP  = 14'b00000000100000,
      S_MOVE1 = 14'b00000001000000,
      S_MOVE2 = 14'b00000010000000,
      S_ADD   = 14'b00000100000000,
      S_ITER  = 14'b00001000000000,
      S_IOUT  = 14'b00010000000000,
      S_SCAN  = 14'b00100000000000,
      S_SBIN  = 14'b01000000000000,
      S_RESP  = 14'b10000000000000
   } state_type;

endpackage

FILE: sv/chsm_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module chsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 rd_en,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                     wdata,
   output logic [WIDTH-1:0]                     rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write or read one word per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/chsm_hash.sv
// Iterative djb2 hash followed by a bit-serial modulo by the bin count.
// Depends on chsm_pkg.
module chsm_hash #(
   parameter int KEY_BYTES = 8,
   parameter int BIN_DEPTH = 1024
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         start,
   input  logic [8*KEY_BYTES-1:0]                       key,
   input  logic [$clog2(BIN_DEPTH+1)-1:0]               divisor,
   output logic [(BIN_DEPTH > 1 ? $clog2(BIN_DEPTH) : 1)-1:0] bin,
   output chsm_pkg::hash_stat_type                      stat
);

   localparam int KW = 8 * KEY_BYTES;
   localparam int CW = $clog2(BIN_DEPTH + 1);
   localparam int BW = (BIN_DEPTH > 1) ? $clog2(BIN_DEPTH) : 1;

   logic                          busy_ff, busy_in;
   logic                          mod_ff, mod_in;
   logic                          done_ff, done_in;
   logic [chsm_pkg::HCNT_W-1:0]   cnt_ff, cnt_in;
   logic [KW-1:0]                 key_ff, key_in;
   logic [chsm_pkg::HASH_BITS-1:0] h_ff, h_in;
   logic [CW-1:0]                 div_ff, div_in;
   logic [CW-1:0]                 rem_ff, rem_in;
   logic [CW:0]                   rem_sh;

   // one byte of hash or one bit of remainder per cycle
   always_comb begin
      busy_in = busy_ff;
      mod_in  = mod_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      key_in  = key_ff;
      h_in    = h_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      rem_sh  = {rem_ff, h_ff[chsm_pkg::HASH_BITS-1]};
      if (start) begin
         busy_in = 1'b1;
         mod_in  = 1'b0;
         cnt_in  = '0;
         key_in  = key;
         h_in    = chsm_pkg::HASH_SEED;
         div_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff && !mod_ff) begin
         h_in   = (h_ff << chsm_pkg::HASH_SHIFT) + h_ff
                  + {{(chsm_pkg::HASH_BITS-8){1'b0}}, key_ff[7:0]};
         key_in = key_ff >> 8;
         if (cnt_ff == chsm_pkg::HCNT_W'(KEY_BYTES - 1)) begin
            mod_in = 1'b1;
            cnt_in = '0;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end else if (busy_ff) begin
         h_in = h_ff << 1;
         if (rem_sh >= {1'b0, div_ff}) begin
            rem_in = CW'(rem_sh - {1'b0, div_ff});
         end else begin
            rem_in = rem_sh[CW-1:0];
         end
         if (cnt_ff == chsm_pkg::HCNT_W'(chsm_pkg::HASH_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         mod_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         mod_ff  <= mod_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      key_ff <= key_in;
      h_ff   <= h_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign bin       = rem_ff[BW-1:0];
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

FILE: sv/chained_hash_store_mtf_unit.sv
// Chained hash key-value store with move-to-front chains; one beat in flight at a time.
// Get/put/put_new: wait on the shared hash and modulo unit, read the bin, read and compare
// each chain record walked (one more check at a chain end), do the move-to-front or add
// writes, then load the result. Iterator next: check the record link, read and check each
// bin scanned, read the record, then load the result. The next beat is taken in the cycle
// after the load. Reset clears bin heads and mark valid bits with a pass over every bin;
// no beat is accepted meanwhile. Depends on chsm_pkg, chsm_ram and chsm_hash.
module chained_hash_store_mtf_unit #(
   parameter int BIN_DEPTH    = 1024,
   parameter int KEY_BYTES    = 8,
   parameter int VALUE_BITS   = 64,
   parameter int RECORD_DEPTH = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic [63:0] req_key,
   input  logic [63:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [63:0] rsp_key_out,
   output logic [63:0] rsp_value_out,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [10:0] csr_bin_count
);

   localparam int KW  = 8 * KEY_BYTES;
   localparam int VB  = VALUE_BITS;
   localparam int PW  = $clog2(RECORD_DEPTH + 1);
   localparam int AW  = $clog2(RECORD_DEPTH);
   localparam int BW  = (BIN_DEPTH > 1) ? $clog2(BIN_DEPTH) : 1;
   localparam int CW  = $clog2(BIN_DEPTH + 1);
   localparam int RW  = PW + VB + KW;
   localparam int BNW = PW + 1;

   chsm_pkg::state_type state_ff, state_in;

   logic [10:0]   cnt_ff;
   logic          dflt_ff;
   logic [CW-1:0] nb;
   logic [BW-1:0] clr_ff, clr_in;
   logic [2:0]    kind_ff, kind_in;
   logic [KW-1:0] key_ff, key_in;
   logic [VB-1:0] val_ff, val_in;
   logic [BW-1:0] bin_ff, bin_in;
   logic [PW-1:0] head_ff, head_in;
   logic          mv_ff, mv_in;
   logic          marked_ff, marked_in;
   logic [PW-1:0] cur_ff, cur_in;
   logic [PW-1:0] prev_ff, prev_in;
   logic [RW-1:0] curw_ff, curw_in;
   logic [RW-1:0] prevw_ff, prevw_in;
   logic [PW-1:0] used_ff, used_in;
   logic [CW-1:0] ibin_ff, ibin_in;
   logic [PW-1:0] inext_ff, inext_in;
   logic [1:0]    res_st_ff, res_st_in;
   logic [63:0]   res_key_ff, res_key_in;
   logic [63:0]   res_val_ff, res_val_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff;
   logic [63:0]   rsp_key_ff, rsp_val_ff;
   logic          out_load;

   logic          rec_rd, rec_wr;
   logic [AW-1:0] rec_addr;
   logic [RW-1:0] rec_wdata, rec_rdata;
   logic          bin_rd, bin_wr;
   logic [BW-1:0] bin_addr;
   logic [BNW-1:0] bin_wdata, bin_rdata;
   logic          mark_rd, mark_wr;
   logic [KW-1:0] mark_rdata;

   logic          hash_start;
   logic [BW-1:0] hash_bin;
   chsm_pkg::hash_stat_type hash_st;

   logic          accept;

   function automatic logic link_ok(input logic [PW-1:0] p);
      return (p != '0) && (32'(p) <= 32'(RECORD_DEPTH));
   endfunction

   function automatic logic [AW-1:0] rec_idx(input logic [PW-1:0] p);
      logic [PW-1:0] d;
      d = p - 1'b1;
      return d[AW-1:0];
   endfunction

   // configuration register; default tracks the full bin depth
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         dflt_ff <= 1'b1;
      end else if (csr_valid) begin
         cnt_ff  <= csr_bin_count;
         dflt_ff <= 1'b0;
      end
   end

   // clamp the bin count into 1..BIN_DEPTH
   always_comb begin
      if (dflt_ff) begin
         nb = CW'(BIN_DEPTH);
      end else if (cnt_ff == '0) begin
         nb = CW'(1);
      end else if (32'(cnt_ff) > 32'(BIN_DEPTH)) begin
         nb = CW'(BIN_DEPTH);
      end else begin
         nb = CW'(cnt_ff);
      end
   end

   assign req_ready  = (state_ff == chsm_pkg::S_IDLE);
   assign accept     = req_valid && req_ready;
   assign hash_start = accept && (req_kind == chsm_pkg::KIND_GET
                       || req_kind == chsm_pkg::KIND_PUT
                       || req_kind == chsm_pkg::KIND_PUT_NEW);
   assign out_load   = (state_ff == chsm_pkg::S_RESP) && (!rsp_valid_ff || rsp_ready);

   // shared hash and modulo unit
   chsm_hash #(
      .KEY_BYTES (KEY_BYTES),
      .BIN_DEPTH (BIN_DEPTH)
   ) u_hash (
      .clock   (clock),
      .reset   (reset),
      .start   (hash_start),
      .key     (req_key[KW-1:0]),
      .divisor (nb),
      .bin     (hash_bin),
      .stat    (hash_st)
   );

   // record pool: {next, value, key}
   chsm_ram #(.WIDTH(RW), .DEPTH(RECORD_DEPTH)) u_rec (
      .clock (clock), .rd_en (rec_rd), .wr_en (rec_wr),
      .addr (rec_addr), .wdata (rec_wdata), .rdata (rec_rdata)
   );

   // bin table: {mark valid, head}
   chsm_ram #(.WIDTH(BNW), .DEPTH(BIN_DEPTH)) u_bin (
      .clock (clock), .rd_en (bin_rd), .wr_en (bin_wr),
      .addr (bin_addr), .wdata (bin_wdata), .rdata (bin_rdata)
   );

   // miss mark keys
   chsm_ram #(.WIDTH(KW), .DEPTH(BIN_DEPTH)) u_mark (
      .clock (clock), .rd_en (mark_rd), .wr_en (mark_wr),
      .addr (bin_addr), .wdata (key_ff), .rdata (mark_rdata)
   );

   // sequencer
   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      kind_in    = kind_ff;
      key_in     = key_ff;
      val_in     = val_ff;
      bin_in     = bin_ff;
      head_in    = head_ff;
      mv_in      = mv_ff;
      marked_in  = marked_ff;
      cur_in     = cur_ff;
      prev_in    = prev_ff;
      curw_in    = curw_ff;
      prevw_in   = prevw_ff;
      used_in    = used_ff;
      ibin_in    = ibin_ff;
      inext_in   = inext_ff;
      res_st_in  = res_st_ff;
      res_key_in = res_key_ff;
      res_val_in = res_val_ff;
      rec_rd     = 1'b0;
      rec_wr     = 1'b0;
      rec_addr   = rec_idx(cur_ff);
      rec_wdata  = curw_ff;
      bin_rd     = 1'b0;
      bin_wr     = 1'b0;
      bin_addr   = bin_ff;
      bin_wdata  = {mv_ff, head_ff};
      mark_rd    = 1'b0;
      mark_wr    = 1'b0;

      unique case (state_ff)
         chsm_pkg::S_CLEAR: begin
            bin_wr    = 1'b1;
            bin_addr  = clr_ff;
            bin_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (32'(clr_ff) == 32'(BIN_DEPTH - 1)) begin
               state_in = chsm_pkg::S_IDLE;
            end
         end
         chsm_pkg::S_IDLE: begin
            if (accept) begin
               kind_in    = req_kind;
               key_in     = req_key[KW-1:0];
               val_in     = req_value[VB-1:0];
               res_key_in = '0;
               res_val_in = '0;
               unique case (req_kind)
                  chsm_pkg::KIND_GET, chsm_pkg::KIND_PUT,
                  chsm_pkg::KIND_PUT_NEW: begin
                     state_in = chsm_pkg::S_HASH;
                  end
                  chsm_pkg::KIND_RESTART: begin
                     ibin_in   = '0;
                     inext_in  = '0;
                     res_st_in = chsm_pkg::STAT_OK;
                     state_in  = chsm_pkg::S_RESP;
                  end
                  chsm_pkg::KIND_NEXT: begin
                     state_in = chsm_pkg::S_ITER;
                  end
                  default: begin
                     res_st_in = chsm_pkg::STAT_MISS;
                     state_in  = chsm_pkg::S_RESP;
                  end
               endcase
            end
         end
         chsm_pkg::S_HASH: begin
            // issue bin and mark reads once the bin is known
            if (hash_st.done) begin
               bin_in   = hash_bin;
               bin_addr = hash_bin;
               bin_rd   = 1'b1;
               mark_rd  = 1'b1;
               state_in = chsm_pkg::S_BIN;
            end
         end
         chsm_pkg::S_BIN: begin
            head_in   = bin_rdata[PW-1:0];
            mv_in     = bin_rdata[PW];
            marked_in = bin_rdata[PW] && (mark_rdata == key_ff);
            cur_in    = bin_rdata[PW-1:0];
            prev_in   = '0;
            if (kind_ff == chsm_pkg::KIND_PUT_NEW) begin
               state_in = chsm_pkg::S_ADD;
            end else if (bin_rdata[PW] && (mark_rdata == key_ff)) begin
               if (kind_ff == chsm_pkg::KIND_GET) begin
                  res_st_in = chsm_pkg::STAT_MISS;
                  state_in  = chsm_pkg::S_RESP;
               end else begin
                  state_in = chsm_pkg::S_ADD;
               end
            end else begin
               state_in = chsm_pkg::S_WALK;
            end
         end
         chsm_pkg::S_WALK: begin
            if (link_ok(cur_ff)) begin
               rec_rd   = 1'b1;
               state_in = chsm_pkg::S_WCMP;
            end else if (kind_ff == chsm_pkg::KIND_GET) begin
               // record the miss mark
               mark_wr   = 1'b1;
               bin_wr    = 1'b1;
               bin_wdata = {1'b1, head_ff};
               mv_in     = 1'b1;
               res_st_in = chsm_pkg::STAT_MISS;
               state_in  = chsm_pkg::S_RESP;
            end else begin
               state_in = chsm_pkg::S_ADD;
            end
         end
         chsm_pkg::S_WCMP: begin
            curw_in = rec_rdata;
            if (rec_rdata[KW-1:0] == key_ff) begin
               res_st_in = chsm_pkg::STAT_OK;
               if (kind_ff == chsm_pkg::KIND_GET) begin
                  res_val_in = 64'(rec_rdata[KW+VB-1:KW]);
               end
               if (prev_ff != '0) begin
                  state_in = chsm_pkg::S_MOVE1;
               end else if (kind_ff == chsm_pkg::KIND_PUT) begin
                  state_in = chsm_pkg::S_MOVE2;
               end else begin
                  state_in = chsm_pkg::S_RESP;
               end
            end else begin
               prev_in  = cur_ff;
               prevw_in = rec_rdata;
               cur_in   = rec_rdata[RW-1:KW+VB];
               state_in = chsm_pkg::S_WALK;
            end
         end
         chsm_pkg::S_MOVE1: begin
            // unlink the hit record and point the bin at it
            rec_wr    = 1'b1;
            rec_addr  = rec_idx(prev_ff);
            rec_wdata = {curw_ff[RW-1:KW+VB], prevw_ff[KW+VB-1:0]};
            bin_wr    = 1'b1;
            bin_wdata = {mv_ff, cur_ff};
            state_in  = chsm_pkg::S_MOVE2;
         end
         chsm_pkg::S_MOVE2: begin
            rec_wr   = 1'b1;
            rec_addr = rec_idx(cur_ff);
            rec_wdata = {(prev_ff != '0) ? head_ff : curw_ff[RW-1:KW+VB],
                         (kind_ff == chsm_pkg::KIND_PUT) ? val_ff : curw_ff[KW+VB-1:KW],
                         curw_ff[KW-1:0]};
            state_in = chsm_pkg::S_RESP;
         end
         chsm_pkg::S_ADD: begin
            if (32'(used_ff) >= 32'(RECORD_DEPTH)) begin
               res_st_in = chsm_pkg::STAT_FULL;
            end else begin
               rec_wr    = 1'b1;
               rec_addr  = used_ff[AW-1:0];
               rec_wdata = {head_ff, val_ff, key_ff};
               bin_wr    = 1'b1;
               bin_wdata = {mv_ff && !marked_ff, used_ff + 1'b1};
               used_in   = used_ff + 1'b1;
               res_st_in = chsm_pkg::STAT_OK;
            end
            state_in = chsm_pkg::S_RESP;
         end
         chsm_pkg::S_ITER: begin
            if (link_ok(inext_ff)) begin
               rec_rd   = 1'b1;
               rec_addr = rec_idx(inext_ff);
               state_in = chsm_pkg::S_IOUT;
            end else begin
               inext_in = '0;
               state_in = chsm_pkg::S_SCAN;
            end
         end
         chsm_pkg::S_IOUT: begin
            res_key_in = 64'(rec_rdata[KW-1:0]);
            res_val_in = 64'(rec_rdata[KW+VB-1:KW]);
            res_st_in  = chsm_pkg::STAT_OK;
            if (link_ok(rec_rdata[RW-1:KW+VB])) begin
               inext_in = rec_rdata[RW-1:KW+VB];
            end else begin
               inext_in = '0;
               ibin_in  = ibin_ff + 1'b1;
            end
            state_in = chsm_pkg::S_RESP;
         end
         chsm_pkg::S_SCAN: begin
            if (ibin_ff < nb) begin
               bin_rd   = 1'b1;
               bin_addr = ibin_ff[BW-1:0];
               state_in = chsm_pkg::S_SBIN;
            end else begin
               res_st_in = chsm_pkg::STAT_END;
               state_in  = chsm_pkg::S_RESP;
            end
         end
         chsm_pkg::S_SBIN: begin
            if (link_ok(bin_rdata[PW-1:0])) begin
               inext_in = bin_rdata[PW-1:0];
               state_in = chsm_pkg::S_ITER;
            end else begin
               ibin_in  = ibin_ff + 1'b1;
               state_in = chsm_pkg::S_SCAN;
            end
         end
         chsm_pkg::S_RESP: begin
            if (out_load) begin
               state_in = chsm_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = chsm_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);

   // control and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= chsm_pkg::S_CLEAR;
         clr_ff       <= '0;
         used_ff      <= '0;
         ibin_ff      <= '0;
         inext_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         used_ff      <= used_in;
         ibin_ff      <= ibin_in;
         inext_ff     <= inext_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff    <= kind_in;
      key_ff     <= key_in;
      val_ff     <= val_in;
      bin_ff     <= bin_in;
      head_ff    <= head_in;
      mv_ff      <= mv_in;
      marked_ff  <= marked_in;
      cur_ff     <= cur_in;
      prev_ff    <= prev_in;
      curw_ff    <= curw_in;
      prevw_ff   <= prevw_in;
      res_st_ff  <= res_st_in;
      res_key_ff <= res_key_in;
      res_val_ff <= res_val_in;
      if (out_load) begin
         rsp_status_ff <= res_st_ff;
         rsp_key_ff    <= res_key_ff;
         rsp_val_ff    <= res_val_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_key_out   = rsp_key_ff;
   assign rsp_value_out = rsp_val_ff;

   // checks
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == chsm_pkg::S_CLEAR |-> !req_ready)
      else $error("request taken during clearing pass");
   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      32'(used_ff) <= 32'(RECORD_DEPTH))
      else $error("record count beyond pool depth");
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second beat taken while busy");
   a_hash_expected: assert property (@(posedge clock) disable iff (reset)
      hash_st.done |-> state_ff == chsm_pkg::S_HASH)
      else $error("hash finished outside hash wait");

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for chained_hash_store_mtf_unit: a directed table, then random
// traffic over several bin counts, ending with a short iterator pass. Depends on chsm_pkg.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NBINS = 1024;
   localparam int NRECS = 4096;

   typedef struct {
      logic [1:0]  status;
      logic [63:0] key_out;
      logic [63:0] value_out;
   } rsp_type;

   typedef struct {
      logic [2:0]  kind;
      logic [63:0] key;
      logic [63:0] value;
      bit          typed;
      rsp_type     want;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_kind = chsm_pkg::KIND_GET;
   logic [63:0] req_key = '0;
   logic [63:0] req_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [63:0] rsp_key_out;
   logic [63:0] rsp_value_out;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [10:0] csr_bin_count = '0;

   chained_hash_store_mtf_unit dut (.*);

   // store image kept by the predictor
   logic [10:0] bin_cfg;
   logic [12:0] head_m[NBINS];
   logic [63:0] mark_key_m[NBINS];
   bit          mark_ok_m[NBINS];
   logic [63:0] rec_key_m[NRECS];
   logic [63:0] rec_val_m[NRECS];
   logic [12:0] rec_next_m[NRECS];
   int          used_m;
   int          iter_bin_m;
   int          iter_rec_m;

   rsp_type pending_rsp[$];
   int   errors = 0;
   bit   calm = 0;
   bit   hold_go = 0;
   bit   hold_on = 0;
   logic [63:0] key_pool[16];

   initial forever #5 clock = ~clock;

   function automatic int live_bins();
      if (bin_cfg == 0) return 1;
      if (int'(bin_cfg) > NBINS) return NBINS;
      return int'(bin_cfg);
   endfunction

   function automatic int djb2_bin(logic [63:0] k);
      logic [63:0] h = 64'd5381;
      for (int i = 0; i < 8; i++) h = (h << 5) + h + 64'(k[8*i +: 8]);
      return int'(h % 64'(live_bins()));
   endfunction

   function automatic bit link_ok(int p);
      return p != 0 && p <= NRECS;
   endfunction

   // search a chain; on a hit move the record to the head, return index+1
   function automatic int find_raise(int b, logic [63:0] k);
      int prev = 0;
      int cur = int'(head_m[b]);
      int steps = 0;
      while (link_ok(cur) && steps < NRECS) begin
         if (rec_key_m[cur-1] == k) begin
            if (prev != 0) begin
               rec_next_m[prev-1] = rec_next_m[cur-1];
               rec_next_m[cur-1] = head_m[b];
               head_m[b] = 13'(cur);
            end
            return cur;
         end
         prev = cur;
         cur = int'(rec_next_m[cur-1]);
         steps++;
      end
      return 0;
   endfunction

   function automatic logic [1:0] link_new(int b, logic [63:0] k, logic [63:0] v);
      if (used_m >= NRECS) return chsm_pkg::STAT_FULL;
      if (mark_ok_m[b] && mark_key_m[b] == k) mark_ok_m[b] = 0;
      rec_key_m[used_m] = k;
      rec_val_m[used_m] = v;
      rec_next_m[used_m] = head_m[b];
      head_m[b] = 13'(used_m + 1);
      used_m++;
      return chsm_pkg::STAT_OK;
   endfunction

   function automatic rsp_type store_step(logic [2:0] kind, logic [63:0] k, logic [63:0] v);
      rsp_type r;
      int b;
      int hit;
      int nb;
      r.status = chsm_pkg::STAT_MISS;
      r.key_out = '0;
      r.value_out = '0;
      case (kind)
         chsm_pkg::KIND_GET: begin
            b = djb2_bin(k);
            if (!(mark_ok_m[b] && mark_key_m[b] == k)) begin
               hit = find_raise(b, k);
               if (hit != 0) begin
                  r.status = chsm_pkg::STAT_OK;
                  r.value_out = rec_val_m[hit-1];
               end else begin
                  mark_key_m[b] = k;
                  mark_ok_m[b] = 1;
               end
            end
         end
         chsm_pkg::KIND_PUT: begin
            b = djb2_bin(k);
            hit = 0;
            if (!(mark_ok_m[b] && mark_key_m[b] == k)) hit = find_raise(b, k);
            if (hit != 0) begin
               rec_val_m[hit-1] = v;
               r.status = chsm_pkg::STAT_OK;
            end else r.status = link_new(b, k, v);
         end
         chsm_pkg::KIND_PUT_NEW: r.status = link_new(djb2_bin(k), k, v);
         chsm_pkg::KIND_RESTART: begin
            iter_bin_m = 0;
            iter_rec_m = 0;
            r.status = chsm_pkg::STAT_OK;
         end
         chsm_pkg::KIND_NEXT: begin
            nb = live_bins();
            if (!link_ok(iter_rec_m)) begin
               iter_rec_m = 0;
               while (iter_bin_m < nb && !link_ok(int'(head_m[iter_bin_m]))) iter_bin_m++;
               if (iter_bin_m < nb) iter_rec_m = int'(head_m[iter_bin_m]);
            end
            if (!link_ok(iter_rec_m)) r.status = chsm_pkg::STAT_END;
            else begin
               r.key_out = rec_key_m[iter_rec_m-1];
               r.value_out = rec_val_m[iter_rec_m-1];
               iter_rec_m = int'(rec_next_m[iter_rec_m-1]);
               if (!link_ok(iter_rec_m)) begin
                  iter_rec_m = 0;
                  iter_bin_m++;
               end
               r.status = chsm_pkg::STAT_OK;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // offer one beat, after a random gap unless calm, record the expectation on acceptance
   task automatic send(logic [2:0] kind, logic [63:0] k, logic [63:0] v,
                       bit typed = 0, rsp_type want = '{default: '0});
      rsp_type got;
      if (!calm) begin
         while ($urandom_range(99) < 38) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_key <= k;
      req_value <= v;
      do @(posedge clock); while (!req_ready);
      got = store_step(kind, k, v);
      pending_rsp.push_back(typed ? want : got);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      wait (pending_rsp.size() == 0);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_bins(logic [10:0] n);
      csr_valid <= 1'b1;
      csr_bin_count <= n;
      do @(posedge clock); while (!csr_ready);
      bin_cfg = n;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic random_item();
      int r = $urandom_range(99);
      logic [63:0] k = ($urandom_range(99) < 85) ? key_pool[$urandom_range(15)] : rand64();
      logic [2:0] kind;
      if (r < 35) kind = chsm_pkg::KIND_GET;
      else if (r < 65) kind = chsm_pkg::KIND_PUT;
      else if (r < 75) kind = chsm_pkg::KIND_PUT_NEW;
      else if (r < 80) kind = chsm_pkg::KIND_RESTART;
      else if (r < 96) kind = chsm_pkg::KIND_NEXT;
      else kind = 3'($urandom_range(7, 5));
      send(kind, k, rand64());
   endtask

   // result side: random backpressure, long hold-off on request
   always @(negedge clock) begin
      if (hold_on) rsp_ready <= 1'b0;
      else if (calm) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(99) >= 38);
   end

   initial begin
      wait (hold_go);
      @(posedge clock);
      hold_on = 1;
      repeat (400) @(posedge clock);
      hold_on = 0;
   end

   // compare each returned beat with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("result beat with nothing expected");
            errors++;
         end else begin
            rsp_type w;
            w = pending_rsp.pop_front();
            if (rsp_status !== w.status) begin
               $error("status: expected %0d, actual %0d", w.status, rsp_status);
               errors++;
            end
            if (rsp_key_out !== w.key_out) begin
               $error("key_out: expected %h, actual %h", w.key_out, rsp_key_out);
               errors++;
            end
            if (rsp_value_out !== w.value_out) begin
               $error("value_out: expected %h, actual %h", w.value_out, rsp_value_out);
               errors++;
            end
         end
      end
   end

   initial begin
      #200ms;
      $display("chained_hash_store_mtf_unit test failed");
      $finish;
   end

   localparam logic [63:0] K1 = 64'h0123_4567_89AB_CDEF;
   localparam logic [63:0] K2 = 64'h8000_0000_0000_0001;
   localparam logic [63:0] ONES = '1;
   localparam rsp_type R_MISS = '{chsm_pkg::STAT_MISS, 64'd0, 64'd0};
   localparam rsp_type R_OK = '{chsm_pkg::STAT_OK, 64'd0, 64'd0};
   localparam rsp_type R_NONE = '{chsm_pkg::STAT_OK, 64'd0, 64'd0};

   row_type dir_rows[] = '{
      '{chsm_pkg::KIND_GET,     K1,    64'd0,  1, R_MISS},
      '{chsm_pkg::KIND_GET,     K1,    64'd0,  1, R_MISS},
      '{chsm_pkg::KIND_PUT,     K1,    64'd11, 1, R_OK},
      '{chsm_pkg::KIND_GET,     K1,    64'd0,  0, R_NONE},
      '{chsm_pkg::KIND_PUT,     K1,    64'd22, 1, R_OK},
      '{chsm_pkg::KIND_PUT_NEW, K1,    64'd33, 1, R_OK},
      '{chsm_pkg::KIND_GET,     K1,    64'd0,  0, R_NONE},
      '{chsm_pkg::KIND_GET,     64'd0, 64'd0,  1, R_MISS},
      '{chsm_pkg::KIND_PUT,     64'd0, 64'd44, 1, R_OK},
      '{chsm_pkg::KIND_GET,     64'd0, 64'd0,  0, R_NONE},
      '{chsm_pkg::KIND_PUT_NEW, ONES,  ONES,   1, R_OK},
      '{chsm_pkg::KIND_GET,     ONES,  64'd0,  0, R_NONE},
      '{chsm_pkg::KIND_GET,     K2,    64'd0,  1, R_MISS},
      '{chsm_pkg::KIND_PUT_NEW, K2,    64'd55, 1, R_OK},
      '{chsm_pkg::KIND_GET,     K2,    64'd0,  0, R_NONE},
      '{chsm_pkg::KIND_RESTART, 64'd0, 64'd0,  1, R_OK},
      '{chsm_pkg::KIND_NEXT,    64'd0, 64'd0,  0, R_NONE},
      '{chsm_pkg::KIND_NEXT,    64'd0, 64'd0,  0, R_NONE},
      '{chsm_pkg::KIND_NEXT,    64'd0, 64'd0,  0, R_NONE},
      '{chsm_pkg::KIND_NEXT,    64'd0, 64'd0,  0, R_NONE},
      '{chsm_pkg::KIND_NEXT,    64'd0, 64'd0,  0, R_NONE},
      '{chsm_pkg::KIND_NEXT,    64'd0, 64'd0,  0, R_NONE},
      '{chsm_pkg::KIND_NEXT,    64'd0, 64'd0,  0, R_NONE},
      '{3'd5,                   ONES,  ONES,   1, R_MISS},
      '{3'd7,                   K1,    64'd1,  1, R_MISS}
   };

   logic [10:0] phase_bins[] = '{11'd1, 11'd0, 11'd2047, 11'd7, 11'd1024};

   initial begin
      bin_cfg = 11'(NBINS);
      used_m = 0;
      iter_bin_m = 0;
      iter_rec_m = 0;
      for (int i = 0; i < NBINS; i++) begin
         head_m[i] = '0;
         mark_ok_m[i] = 0;
      end
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (dir_rows[i])
         send(dir_rows[i].kind, dir_rows[i].key, dir_rows[i].value,
              dir_rows[i].typed, dir_rows[i].want);
      drain();

      // random traffic under several bin counts
      foreach (phase_bins[p]) begin
         write_bins(phase_bins[p]);
         foreach (key_pool[i]) key_pool[i] = (i == 0) ? 64'd0 : rand64();
         calm = (p == 3);
         for (int n = 0; n < 130; n++) begin
            if (p == 1 && n == 20) hold_go = 1;
            if (p == 2 && n == 60) drain();
            random_item();
         end
         drain();
      end

      // final put, get and iterator pass at the full bin count
      calm = 0;
      write_bins(11'd1024);
      send(chsm_pkg::KIND_PUT, K2, 64'd66);
      send(chsm_pkg::KIND_GET, K2, 64'd0);
      send(chsm_pkg::KIND_RESTART, 64'd0, 64'd0, 1, R_OK);
      repeat (6) send(chsm_pkg::KIND_NEXT, 64'd0, 64'd0);
      drain();
      repeat (100) @(negedge clock);
      if (errors == 0) $display("chained_hash_store_mtf_unit test passed");
      else $display("chained_hash_store_mtf_unit test failed");
      $finish;
   end
endmodule

FILE: files.f
sv/chsm_pkg.sv
sv/chsm_ram.sv
sv/chsm_hash.sv
sv/chained_hash_store_mtf_unit.sv
tb/sv/testbench.sv
